// ===== design/sps_pkg.sv =====
// shared types and constants for the slotted page store
package sps_pkg;
  localparam int PageBytes   = 1024;
  localparam int HeaderBytes = 4;
  localparam int MaxEntries  = 255;
  localparam int SlotBytes   = 4;
  localparam int AddrW = $clog2(PageBytes);
  localparam int OffW  = AddrW + 1;
  localparam int IdxW  = $clog2(MaxEntries);
  localparam int CntW  = $clog2(MaxEntries + 1);

  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_BEGIN  = 3'd1,
    KIND_ADD    = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_READ   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_ROOM   = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_NO_ADD    = 3'd3,
    ST_BAD_OFF   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_TOP, S_DECIDE, S_RDB, S_RDW, S_MVR, S_MVW, S_TBR, S_TBW,
    S_FIN, S_OUT
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic rd_top;
    logic rd_idx;
    logic rd_prev;
    logic decide;
    logic byte_rd;
    logic mv_rd;
    logic mv_wr;
    logic tb_rd;
    logic tb_wr;
    logic finish;
  } cmd_t;

  // datapath status back to controller
  typedef struct packed {
    logic   bad_idx;
    logic   remove_go;
    logic   read_go;
    logic   mv_done;
    logic   tb_done;
    logic   [2:0] kind;
  } sts_t;
endpackage

// ===== design/sps_ctrl.sv =====
// sequencer for the slotted page store
module sps_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  logic          out_busy_i,
  input  sps_pkg::sts_t sts_i,
  output sps_pkg::cmd_t cmd_o,
  output logic          idle_o,
  output logic          out_load_o
);
  import sps_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    out_load_o = 1'b0;
    idle_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        idle_o = 1'b1;
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          state_d = S_TOP;
        end
      end
      S_TOP: begin
        cmd_o.rd_top = 1'b1;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.rd_idx = 1'b1;
        state_d = S_RDB;
      end
      S_RDB: begin
        cmd_o.rd_prev = 1'b1;
        state_d = S_RDW;
      end
      S_RDW: begin
        cmd_o.decide = 1'b1;
        if (sts_i.remove_go) begin
          state_d = S_MVR;
        end else if (sts_i.read_go) begin
          cmd_o.byte_rd = 1'b1;
          state_d = S_FIN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MVR: begin
        if (sts_i.mv_done) begin
          state_d = S_TBR;
        end else begin
          cmd_o.mv_rd = 1'b1;
          state_d = S_MVW;
        end
      end
      S_MVW: begin
        cmd_o.mv_wr = 1'b1;
        state_d = S_MVR;
      end
      S_TBR: begin
        if (sts_i.tb_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.tb_rd = 1'b1;
          state_d = S_TBW;
        end
      end
      S_TBW: begin
        cmd_o.tb_wr = 1'b1;
        state_d = S_TBR;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_busy_i) begin
          out_load_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // assertions
  a_idle_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i |-> state_q == S_IDLE) else $error("accept outside idle");
  a_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |=> state_q == S_IDLE) else $error("result not followed by idle");
  a_mv_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mv_rd |=> cmd_o.mv_wr) else $error("move read without write");
endmodule

// ===== design/sps_dp.sv =====
// datapath: byte store, offset table, counters and result registers
module sps_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sps_pkg::cmd_t       cmd_i,
  output sps_pkg::sts_t       sts_o,
  input  logic [2:0]          kind_i,
  input  logic [9:0]          size_i,
  input  logic [7:0]          data_i,
  input  logic [7:0]          idx_i,
  input  logic [9:0]          off_i,
  output logic [2:0]          status_o,
  output logic [7:0]          entry_id_o,
  output logic [7:0]          read_byte_o,
  output logic [9:0]          object_length_o,
  output logic [9:0]          free_bytes_o,
  output logic [7:0]          entry_count_o
);
  import sps_pkg::*;

  logic [7:0]      mem_q [PageBytes];
  logic [OffW-1:0] tab_q [MaxEntries];

  logic [CntW-1:0] held_q;
  logic [OffW-1:0] fill_addr_q;
  logic [OffW-1:0] fill_rem_q;
  logic [OffW-1:0] top_q, lowest_q, cur_q, prev_q;
  logic [2:0]      kind_q;
  logic [9:0]      size_q, off_q;
  logic [7:0]      data_q, idx_q;
  logic [2:0]      st_q;
  logic [7:0]      id_q, rb_q;
  logic [OffW-1:0] olen_q, gap_q;
  logic [OffW-1:0] mv_src_q, mv_dst_q;
  logic [CntW-1:0] tb_i_q;
  logic            rgo_q;

  // free bytes from the lowest object start
  logic signed [OffW+CntW+2:0] free_s;
  logic [OffW-1:0]             free_now;
  always_comb begin
    free_s = $signed({3'b0, CntW'(0), lowest_q}) - (OffW+CntW+3)'(HeaderBytes)
           - $signed((OffW+CntW+3)'(SlotBytes) * {{(OffW+3){1'b0}}, held_q});
    free_now = free_s < 0 ? '0 : OffW'(free_s);
  end

  // table data is tab[idx-1] while the item is decided
  logic bad_idx, idx_last, begin_ok;
  logic [OffW-1:0] prev_now, len_now;
  assign bad_idx  = {1'b0, idx_q} >= (CntW+1)'(held_q);
  assign idx_last = (CntW+1)'({1'b0, idx_q}) + 1'b1 == (CntW+1)'(held_q);
  assign prev_now = idx_q == 8'd0 ? OffW'(PageBytes) : tab_rd_q;
  assign len_now  = prev_now - cur_q;
  assign begin_ok = held_q < CntW'(MaxEntries) &&
                    (OffW+1)'(size_q) + (OffW+1)'(SlotBytes) <= (OffW+1)'(free_now);

  // item outcome
  logic [2:0]      st_d;
  logic [7:0]      id_d;
  logic [OffW-1:0] olen_d;
  logic            rgo_d;
  always_comb begin
    st_d   = ST_OK;
    id_d   = '0;
    olen_d = '0;
    rgo_d  = 1'b0;
    unique case (kind_q)
      KIND_BEGIN: begin
        if (begin_ok) id_d = 8'(held_q);
        else st_d = ST_NO_ROOM;
      end
      KIND_ADD: if (fill_rem_q == '0) st_d = ST_NO_ADD;
      KIND_REMOVE: if (bad_idx) st_d = ST_BAD_INDEX;
      KIND_READ: begin
        if (bad_idx) begin
          st_d = ST_BAD_INDEX;
        end else begin
          olen_d = len_now;
          if (OffW'(off_q) >= len_now) st_d = ST_BAD_OFF;
          else rgo_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign sts_o.bad_idx   = bad_idx;
  assign sts_o.remove_go = kind_q == KIND_REMOVE && !bad_idx && !idx_last;
  assign sts_o.read_go   = rgo_d;
  assign sts_o.mv_done   = mv_src_q == lowest_q;
  assign sts_o.tb_done   = tb_i_q + 1'b1 >= held_q;
  assign sts_o.kind      = kind_q;

  logic [IdxW-1:0] rd_at;
  always_comb begin
    rd_at = '0;
    if (cmd_i.rd_top) rd_at = IdxW'(held_q - 1'b1);
    else if (cmd_i.rd_idx) rd_at = IdxW'(idx_q);
    else if (cmd_i.rd_prev) rd_at = IdxW'(idx_q - 1'b1);
    else rd_at = IdxW'(tb_i_q + 1'b1);
  end

  logic [OffW-1:0] tab_rd_q;
  logic [7:0]      mem_rd_q;
  logic [OffW-1:0] mem_rd_at;
  assign mem_rd_at = cmd_i.byte_rd ? cur_q + OffW'(off_q) : mv_src_q - 1'b1;

  // memories
  always_ff @(posedge clk_i) begin
    tab_rd_q <= tab_q[rd_at];
    mem_rd_q <= mem_q[mem_rd_at[AddrW-1:0]];
    if (cmd_i.decide && kind_q == KIND_BEGIN && begin_ok)
      tab_q[IdxW'(held_q)] <= top_q - OffW'(size_q);
    if (cmd_i.decide && kind_q == KIND_ADD && fill_rem_q != '0 && !fill_addr_q[AddrW])
      mem_q[fill_addr_q[AddrW-1:0]] <= data_q;
    if (cmd_i.mv_wr)
      mem_q[AddrW'(mv_dst_q - 1'b1)] <= mem_rd_q;
    if (cmd_i.tb_wr)
      tab_q[IdxW'(tb_i_q)] <= tab_rd_q + gap_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      fill_addr_q <= '0;
      fill_rem_q  <= '0;
      lowest_q    <= OffW'(PageBytes);
    end else begin
      if (cmd_i.decide) begin
        unique case (kind_q)
          KIND_CLEAR: begin
            held_q <= '0;
            fill_rem_q <= '0;
            lowest_q <= OffW'(PageBytes);
          end
          KIND_BEGIN: begin
            if (begin_ok) begin
              held_q <= held_q + 1'b1;
              fill_addr_q <= top_q - OffW'(size_q);
              fill_rem_q <= OffW'(size_q);
              lowest_q <= top_q - OffW'(size_q);
            end else begin
              fill_rem_q <= '0;
            end
          end
          KIND_ADD: begin
            if (fill_rem_q != '0) begin
              fill_addr_q <= fill_addr_q + 1'b1;
              fill_rem_q <= fill_rem_q - 1'b1;
            end
          end
          KIND_REMOVE: begin
            fill_rem_q <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.finish && kind_q == KIND_REMOVE && !bad_idx) begin
        held_q <= held_q - 1'b1;
        if (!idx_last) lowest_q <= lowest_q + gap_q;
        else if (held_q == CntW'(1)) lowest_q <= OffW'(PageBytes);
        else lowest_q <= prev_q;
      end
    end
  end

  // item registers, table reads and walk pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i; size_q <= size_i; data_q <= data_i;
      idx_q <= idx_i; off_q <= off_i;
    end
    if (cmd_i.rd_idx) top_q <= held_q == 0 ? OffW'(PageBytes) : tab_rd_q;
    if (cmd_i.rd_prev) cur_q <= tab_rd_q;
    if (cmd_i.decide) begin
      prev_q   <= prev_now;
      st_q     <= st_d;
      id_q     <= id_d;
      olen_q   <= olen_d;
      rgo_q    <= rgo_d;
      gap_q    <= len_now;
      mv_src_q <= cur_q;
      mv_dst_q <= prev_now;
      tb_i_q   <= CntW'(idx_q);
    end
    if (cmd_i.mv_wr) begin
      mv_src_q <= mv_src_q - 1'b1;
      mv_dst_q <= mv_dst_q - 1'b1;
    end
    if (cmd_i.tb_wr) tb_i_q <= tb_i_q + 1'b1;
    if (cmd_i.finish) rb_q <= rgo_q ? mem_rd_q : 8'd0;
  end

  assign status_o        = st_q;
  assign entry_id_o      = id_q;
  assign read_byte_o     = rb_q;
  assign object_length_o = 10'(olen_q);
  assign free_bytes_o    = 10'(free_now);
  assign entry_count_o   = 8'(held_q);

  // assertions
  a_held_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CntW'(MaxEntries)) else $error("entry count overflow");
  a_lowest_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q == 0 |-> lowest_q == OffW'(PageBytes)) else $error("empty page not at end");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_rem_q != 0 |-> fill_rem_q <= OffW'(PageBytes)) else $error("fill count out of range");
endmodule

// ===== design/slotted_page_store_top.sv =====
// slotted page store: stream wrapper around controller and datapath
// usage:
//   items arrive on the s_axis group: tdata packs object_size, data_byte,
//   entry_index and byte_offset, tuser carries the kind. one result per item
//   leaves on the m_axis group: tdata packs status, entry_id, read_byte,
//   object_length, free_bytes and entry_count from bit 0 up.
// sequencing:
//   one item at a time. clear, begin add, add byte and read step through
//   the table reads, decide, finish and output states (table and byte
//   memory read ports, each registered). remove of a non-last entry adds
//   a read and a write state per byte moved (the bytes of all later objects)
//   plus a read and a write state per table entry shifted plus the two end
//   checks. a new item is taken the cycle after the result enters the
//   output register.
// reset:
//   clears entry count and open add; byte store and table are not cleared.
// stall:
//   a held result stays in the output register; the block stalls
//   its next result until the receiver takes the current one.
module slotted_page_store_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // object_size, data_byte, entry_index, byte_offset
  input  logic [2:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status, entry_id, read_byte, object_length,
                                     // free_bytes, entry_count
);
  import sps_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic idle, out_load, in_fire;
  logic [2:0] st;
  logic [7:0] id, rb, cnt;
  logic [9:0] ol, fb;
  logic [47:0] out_q;
  logic        vld_q;

  assign s_axis_tready = idle;
  assign in_fire = s_axis_tvalid & idle;

  sps_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_busy_i(vld_q & ~m_axis_tready),
    .sts_i(sts), .cmd_o(cmd), .idle_o(idle), .out_load_o(out_load)
  );

  sps_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .kind_i(s_axis_tuser), .size_i(s_axis_tdata[9:0]),
    .data_i(s_axis_tdata[17:10]), .idx_i(s_axis_tdata[25:18]),
    .off_i(s_axis_tdata[35:26]),
    .status_o(st), .entry_id_o(id), .read_byte_o(rb), .object_length_o(ol),
    .free_bytes_o(fb), .entry_count_o(cnt)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (out_load) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= {1'b0, cnt, fb, ol, rb, id, st};
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = out_q;
endmodule

// ===== dv/tb_top.sv =====
// stream testbench for the slotted page store with a self-checking page scoreboard
`timescale 1ns / 1ps

module tb_top;
  import sps_pkg::*;

  // page scoreboard: mirrors the page contents and queues the expected responses
  class page_scoreboard;
    logic [7:0]  page_mem[PageBytes];
    bit          byte_known[PageBytes];
    int unsigned slot_start[MaxEntries];
    int unsigned held;
    int unsigned fill_addr;
    int unsigned fill_left;
    logic [47:0] pending_q[$];
    int unsigned errors;

    function new();
      held = 0;
      fill_addr = 0;
      fill_left = 0;
      errors = 0;
      foreach (byte_known[i]) byte_known[i] = 0;
      foreach (page_mem[i]) page_mem[i] = '0;
    endfunction

    function int unsigned free_space();
      int f;
      if (held == 0) f = PageBytes - HeaderBytes;
      else f = int'(slot_start[held-1]) - HeaderBytes - SlotBytes * int'(held);
      return (f < 0) ? 0 : f;
    endfunction

    function int unsigned obj_len(int unsigned idx);
      int unsigned stop;
      stop = (idx == 0) ? PageBytes : slot_start[idx-1];
      return stop - slot_start[idx];
    endfunction

    // apply one accepted beat and queue the response it causes
    function void note_item(logic [2:0] kind, logic [9:0] size, logic [7:0] data,
                            logic [7:0] idx, logic [9:0] off);
      status_e st;
      int unsigned id, rb, olen, top, gap, src, span, i;
      logic [9:0] fb;
      logic [7:0] tmp[PageBytes];
      bit tk[PageBytes];
      st = ST_OK; id = 0; rb = 0; olen = 0;
      case (kind)
        KIND_CLEAR: begin
          held = 0;
          fill_left = 0;
        end
        KIND_BEGIN: begin
          fill_left = 0;
          if (held >= MaxEntries || size + SlotBytes > free_space()) begin
            st = ST_NO_ROOM;
          end else begin
            top = (held == 0) ? PageBytes : slot_start[held-1];
            slot_start[held] = top - size;
            id = held;
            held++;
            fill_addr = top - size;
            fill_left = size;
          end
        end
        KIND_ADD: begin
          if (fill_left == 0) begin
            st = ST_NO_ADD;
          end else begin
            if (fill_addr < PageBytes) begin
              page_mem[fill_addr] = data;
              byte_known[fill_addr] = 1;
            end
            fill_addr++;
            fill_left--;
          end
        end
        KIND_REMOVE: begin
          fill_left = 0;
          if (idx >= held) begin
            st = ST_BAD_INDEX;
          end else begin
            if (idx != held - 1) begin
              gap = obj_len(idx);
              src = slot_start[held-1];
              span = slot_start[idx] - src;
              if (src + gap + span <= PageBytes) begin
                for (i = 0; i < span; i++) begin
                  tmp[i] = page_mem[src+i];
                  tk[i] = byte_known[src+i];
                end
                for (i = 0; i < span; i++) begin
                  page_mem[src+gap+i] = tmp[i];
                  byte_known[src+gap+i] = tk[i];
                end
              end
              for (i = idx; i < held - 1; i++) slot_start[i] = slot_start[i+1] + gap;
            end
            held--;
          end
        end
        KIND_READ: begin
          if (idx >= held) begin
            st = ST_BAD_INDEX;
          end else begin
            olen = obj_len(idx);
            if (off >= olen) st = ST_BAD_OFF;
            else if (slot_start[idx] + off < PageBytes) rb = page_mem[slot_start[idx] + off];
          end
        end
        default: ;
      endcase
      fb = 10'(free_space());
      pending_q.push_back({held[7:0], fb, olen[9:0], rb[7:0], id[7:0], st});
    endfunction

    // compare one response beat with the oldest expectation
    function void check_result(logic [47:0] got);
      logic [47:0] want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected response %h", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got[46:0] !== want[46:0]) begin
        $display("%0t: mismatch expected st=%0d id=%0d rb=%0d len=%0d free=%0d cnt=%0d",
                 $time, want[2:0], want[10:3], want[18:11], want[28:19], want[38:29],
                 want[46:39]);
        $display("%0t:          actual   st=%0d id=%0d rb=%0d len=%0d free=%0d cnt=%0d",
                 $time, got[2:0], got[10:3], got[18:11], got[28:19], got[38:29],
                 got[46:39]);
        errors++;
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  page_scoreboard sb;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned quiet_cycles;
  int unsigned sent;
  bit          timed_out;

  slotted_page_store_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // response side: random backpressure and checking
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchdogLimit && !timed_out) begin
      timed_out = 1;
      $display("FAIL");
      $finish;
    end
  end

  // drive one beat and wait for it to be taken
  task automatic send_item(logic [2:0] kind, logic [9:0] size, logic [7:0] data,
                           logic [7:0] idx, logic [9:0] off);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'd0, off, idx, data, size};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(kind, size, data, idx, off);
    sent++;
  endtask

  // begin add followed by its fill bytes
  task automatic add_object(int unsigned size);
    int unsigned i;
    int unsigned was;
    was = sb.held;
    send_item(KIND_BEGIN, 10'(size), 8'($urandom), 0, 0);
    if (sb.held != was)
      for (i = 0; i < size; i++) send_item(KIND_ADD, 0, 8'($urandom), 0, 0);
  endtask

  // read that never touches a byte never written
  task automatic read_entry(int unsigned idx);
    int unsigned len, off;
    off = $urandom_range(1023);
    if (idx < sb.held) begin
      len = sb.obj_len(idx);
      if (len > 0 && $urandom_range(3) != 0) off = $urandom_range(len - 1);
      if (off < len && !sb.byte_known[sb.slot_start[idx] + off]) off = len;
    end
    send_item(KIND_READ, 10'($urandom), 8'($urandom), 8'(idx), 10'(off));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned r, i;
    bit fast_done, fill_done;
    sb = new();
    timed_out = 0;
    quiet_cycles = 0;
    sent = 0;
    fast_done = 0;
    fill_done = 0;
    src_idle_pct = 30;
    snk_idle_pct = 30;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = KIND_CLEAR;
    m_axis_tready = 0;
    rst_ni = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, room limits, open-add handling, compaction
    send_item(KIND_CLEAR, 0, 0, 0, 0);
    send_item(KIND_ADD, 10'h3FF, 8'hFF, 8'hFF, 10'h3FF);
    send_item(KIND_BEGIN, 1020, 0, 0, 0);
    send_item(KIND_BEGIN, 1016, 0, 0, 0);
    send_item(KIND_ADD, 0, 8'hFF, 0, 0);
    send_item(KIND_ADD, 0, 8'h00, 0, 0);
    send_item(KIND_BEGIN, 0, 0, 0, 0);
    read_entry(0);
    send_item(KIND_READ, 0, 0, 0, 10'd1016);
    send_item(KIND_REMOVE, 0, 0, 0, 0);
    send_item(KIND_BEGIN, 0, 0, 0, 0);
    add_object(3);
    send_item(KIND_BEGIN, 6, 0, 0, 0);
    send_item(KIND_ADD, 0, 8'hA5, 0, 0);
    add_object(2);
    read_entry(2);
    send_item(KIND_READ, 0, 0, 254, 0);
    send_item(KIND_REMOVE, 0, 0, 254, 0);
    send_item(3'd7, 10'h3FF, 8'hFF, 8'hFF, 10'h3FF);
    send_item(3'd5, 0, 0, 0, 0);
    send_item(KIND_REMOVE, 0, 0, 1, 0);
    read_entry(1);
    send_item(KIND_READ, 0, 0, 2, 0);
    send_item(KIND_CLEAR, 0, 0, 0, 0);

    // random: mostly well-formed adds with reads and removes, plus noise
    while (sent < 600) begin
      if (sent >= 150 && !fast_done) begin
        fast_done = 1;
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (sent >= 260 && !fill_done) begin
        fill_done = 1;
        src_idle_pct = 30;
        snk_idle_pct = 30;
        wait_drained();
        send_item(KIND_CLEAR, 0, 0, 0, 0);
        // fill the table with empty objects up to the entry limit and beyond
        for (i = 0; i < MaxEntries + 1; i++) send_item(KIND_BEGIN, 0, 0, 0, 0);
        send_item(KIND_REMOVE, 0, 0, 0, 0);
        send_item(KIND_CLEAR, 0, 0, 0, 0);
      end
      r = $urandom_range(99);
      if (r < 35) begin
        if ($urandom_range(19) == 0) add_object($urandom_range(160));
        else add_object($urandom_range(24));
      end else if (r < 58) begin
        read_entry(sb.held == 0 ? 0 : $urandom_range(sb.held - 1));
      end else if (r < 70) begin
        send_item(KIND_REMOVE, 10'($urandom), 8'($urandom),
                  8'((sb.held == 0 || $urandom_range(7) == 0) ? $urandom_range(254)
                                                              : $urandom_range(sb.held - 1)),
                  0);
      end else if (r < 74) begin
        send_item(KIND_CLEAR, 10'($urandom), 8'($urandom), 8'($urandom), 0);
      end else if (r < 82) begin
        send_item(KIND_BEGIN, 10'($urandom_range(24)), 0, 0, 0);
        for (i = $urandom_range(3); i > 0; i--) send_item(KIND_ADD, 0, 8'($urandom), 0, 0);
      end else if (r < 90) begin
        send_item(KIND_ADD, 10'($urandom), 8'($urandom), 8'($urandom), 10'($urandom));
      end else if (r < 95) begin
        read_entry($urandom_range(254));
      end else begin
        send_item(3'($urandom_range(7, 5)), 10'($urandom), 8'($urandom), 8'($urandom),
                  10'($urandom));
      end
    end

    wait_drained();
    repeat (3000) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/sps_pkg.sv
design/sps_ctrl.sv
design/sps_dp.sv
design/slotted_page_store_top.sv
dv/tb_top.sv
